/* src/cdsl_pkg.sv */
// shared types, constants and index helpers for the circular deque with sorted insert
package cdsl_pkg;

    // store geometry
    localparam int STORE_DEPTH = 16;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int FUNC_W      = 3;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;

    // command codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_INSERT     = 3'd4,
        FN_REMOVE     = 3'd5
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_INS_RD,
        S_INS_CK,
        S_SHF_RD,
        S_SHF_CK,
        S_REM_RD,
        S_REM_CK,
        S_DEL_RD,
        S_DEL_CK,
        S_RESULT
    } t_state;

    // cursor update
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_HEAD,
        CUR_INC
    } t_cur_op;

    // head / tail pointer update
    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    // read address select
    typedef enum logic [1:0] {
        RD_CUR,
        RD_CUR_INC,
        RD_HEAD,
        RD_TAIL_DEC
    } t_rd_sel;

    // write address select
    typedef enum logic [1:0] {
        WR_CUR,
        WR_HEAD_DEC,
        WR_TAIL
    } t_wr_sel;

    // write data select
    typedef enum logic [1:0] {
        WD_VAL,
        WD_CARRY,
        WD_RDATA
    } t_wd_sel;

    // controller to datapath
    typedef struct packed {
        logic    load_cmd;
        t_cur_op cur_op;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_wd_sel wd_sel;
        t_ptr_op head_op;
        t_ptr_op tail_op;
        logic    carry_ld_val;
        logic    carry_ld_rdata;
        logic    st_ld;
        t_status st_val;
        logic    pop_clr;
        logic    pop_ld;
        logic    out_ld;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  cur_at_tail;
        logic  cur_inc_at_tail;
        logic  rd_le;
        logic  rd_eq;
        logic  out_free;
    } t_dp_stat;

    // circular increment
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(STORE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    // circular decrement
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(STORE_DEPTH - 1) : i - IDX_W'(1);
    endfunction

endpackage

/* src/cdsl_dp.sv */
// datapath: word store, head/tail/cursor pointers, carry word and result register
module cdsl_dp
    import cdsl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DATA_W-1:0]   i_data,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [DATA_W-1:0]   o_m_axis_tdata,
    output logic [STATUS_W-1:0] o_m_axis_tuser
);

    logic [DATA_W-1:0]   r_mem [STORE_DEPTH];
    logic [DATA_W-1:0]   r_rdata;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDX_W-1:0]    r_tail, n_tail;
    logic [IDX_W-1:0]    r_cur,  n_cur;
    t_func               r_func;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_carry;
    t_status             r_status;
    logic [DATA_W-1:0]   r_popped;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic [STATUS_W-1:0] r_out_user;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;

    // address and data selection
    always_comb begin
        case (i_cmd.rd_sel)
            RD_CUR:      rd_addr = r_cur;
            RD_CUR_INC:  rd_addr = idx_inc(r_cur);
            RD_HEAD:     rd_addr = r_head;
            RD_TAIL_DEC: rd_addr = idx_dec(r_tail);
            default:     rd_addr = r_cur;
        endcase
        case (i_cmd.wr_sel)
            WR_CUR:      wr_addr = r_cur;
            WR_HEAD_DEC: wr_addr = idx_dec(r_head);
            WR_TAIL:     wr_addr = r_tail;
            default:     wr_addr = r_cur;
        endcase
        case (i_cmd.wd_sel)
            WD_VAL:   wr_data = r_val;
            WD_CARRY: wr_data = r_carry;
            WD_RDATA: wr_data = r_rdata;
            default:  wr_data = r_val;
        endcase
    end

    // word store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // pointer next values
    always_comb begin
        case (i_cmd.head_op)
            PTR_INC: n_head = idx_inc(r_head);
            PTR_DEC: n_head = idx_dec(r_head);
            default: n_head = r_head;
        endcase
        case (i_cmd.tail_op)
            PTR_INC: n_tail = idx_inc(r_tail);
            PTR_DEC: n_tail = idx_dec(r_tail);
            default: n_tail = r_tail;
        endcase
        case (i_cmd.cur_op)
            CUR_HEAD: n_cur = r_head;
            CUR_INC:  n_cur = idx_inc(r_cur);
            default:  n_cur = r_cur;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_cmd.load_cmd) begin
            r_func <= t_func'(i_func);
            r_val  <= i_data;
        end
        if (i_cmd.carry_ld_val) begin
            r_carry <= r_val;
        end else if (i_cmd.carry_ld_rdata) begin
            r_carry <= r_rdata;
        end
        if (i_cmd.st_ld) begin
            r_status <= i_cmd.st_val;
        end
        if (i_cmd.pop_clr) begin
            r_popped <= '0;
        end else if (i_cmd.pop_ld) begin
            r_popped <= r_rdata;
        end
        if (i_cmd.out_ld) begin
            r_out_data <= r_popped;
            r_out_user <= r_status;
        end
    end

    // status to controller
    always_comb begin
        o_stat.func            = r_func;
        o_stat.full            = (r_head == idx_inc(r_tail));
        o_stat.empty           = (r_head == r_tail);
        o_stat.cur_at_tail     = (r_cur == r_tail);
        o_stat.cur_inc_at_tail = (idx_inc(r_cur) == r_tail);
        o_stat.rd_le           = ($signed(r_rdata) <= $signed(r_val));
        o_stat.rd_eq           = (r_rdata == r_val);
        o_stat.out_free        = !r_out_valid || i_m_axis_tready;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

/* src/cdsl_ctrl.sv */
// controller: sequences push, pop, sorted insert and sorted remove over the datapath
module cdsl_ctrl
    import cdsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '{
            load_cmd:       1'b0,
            cur_op:         CUR_HOLD,
            rd_en:          1'b0,
            rd_sel:         RD_CUR,
            wr_en:          1'b0,
            wr_sel:         WR_CUR,
            wd_sel:         WD_VAL,
            head_op:        PTR_HOLD,
            tail_op:        PTR_HOLD,
            carry_ld_val:   1'b0,
            carry_ld_rdata: 1'b0,
            st_ld:          1'b0,
            st_val:         ST_OK,
            pop_clr:        1'b0,
            pop_ld:         1'b0,
            out_ld:         1'b0
        };
        o_s_axis_tready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load_cmd = 1'b1;
                    n_state        = S_EXEC;
                end
            end

            // decide the command; pushes, refused and unknown commands finish here
            S_EXEC: begin
                o_cmd.pop_clr = 1'b1;
                o_cmd.st_ld   = 1'b1;
                n_state       = S_RESULT;
                case (i_stat.func)
                    FN_PUSH_FRONT: begin
                        if (i_stat.full) begin
                            o_cmd.st_val = ST_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = WR_HEAD_DEC;
                            o_cmd.head_op = PTR_DEC;
                        end
                    end
                    FN_PUSH_BACK: begin
                        if (i_stat.full) begin
                            o_cmd.st_val = ST_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = WR_TAIL;
                            o_cmd.tail_op = PTR_INC;
                        end
                    end
                    FN_POP_FRONT: begin
                        if (i_stat.empty) begin
                            o_cmd.st_val = ST_EMPTY;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = RD_HEAD;
                            o_cmd.head_op = PTR_INC;
                            n_state       = S_POP_WAIT;
                        end
                    end
                    FN_POP_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.st_val = ST_EMPTY;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = RD_TAIL_DEC;
                            o_cmd.tail_op = PTR_DEC;
                            n_state       = S_POP_WAIT;
                        end
                    end
                    FN_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.st_val = ST_FULL;
                        end else begin
                            o_cmd.cur_op       = CUR_HEAD;
                            o_cmd.carry_ld_val = 1'b1;
                            n_state            = S_INS_RD;
                        end
                    end
                    FN_REMOVE: begin
                        if (i_stat.empty) begin
                            o_cmd.st_val = ST_EMPTY;
                        end else begin
                            o_cmd.cur_op = CUR_HEAD;
                            n_state      = S_REM_RD;
                        end
                    end
                    default: begin
                        o_cmd.st_val = ST_OK;
                    end
                endcase
            end

            S_POP_WAIT: begin
                o_cmd.pop_ld = 1'b1;
                n_state      = S_RESULT;
            end

            // insert scan and ripple: the carry word drops into place at the tail
            S_INS_RD, S_SHF_RD: begin
                if (i_stat.cur_at_tail) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_CUR;
                    o_cmd.wd_sel  = WD_CARRY;
                    o_cmd.tail_op = PTR_INC;
                    n_state       = S_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_CUR;
                    n_state      = (r_state == S_INS_RD) ? S_INS_CK : S_SHF_CK;
                end
            end

            // still scanning while stored word <= new word, else start swapping
            S_INS_CK, S_SHF_CK: begin
                o_cmd.cur_op = CUR_INC;
                if (r_state == S_INS_CK && i_stat.rd_le) begin
                    n_state = S_INS_RD;
                end else begin
                    o_cmd.wr_en          = 1'b1;
                    o_cmd.wr_sel         = WR_CUR;
                    o_cmd.wd_sel         = WD_CARRY;
                    o_cmd.carry_ld_rdata = 1'b1;
                    n_state              = S_SHF_RD;
                end
            end

            // remove scan for the first equal word
            S_REM_RD: begin
                if (i_stat.cur_at_tail) begin
                    o_cmd.st_ld  = 1'b1;
                    o_cmd.st_val = ST_NOTFOUND;
                    n_state      = S_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_CUR;
                    n_state      = S_REM_CK;
                end
            end

            S_REM_CK: begin
                if (i_stat.rd_eq) begin
                    n_state = S_DEL_RD;
                end else begin
                    o_cmd.cur_op = CUR_INC;
                    n_state      = S_REM_RD;
                end
            end

            // close the gap: move each later word down by one
            S_DEL_RD: begin
                if (i_stat.cur_inc_at_tail) begin
                    o_cmd.tail_op = PTR_DEC;
                    n_state       = S_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_CUR_INC;
                    n_state      = S_DEL_CK;
                end
            end

            S_DEL_CK: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_CUR;
                o_cmd.wd_sel = WD_RDATA;
                o_cmd.cur_op = CUR_INC;
                n_state      = S_DEL_RD;
            end

            // hand the result to the output register once it has room
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/circular_deque_sorted_list_top.sv */
// top level of the circular deque with sorted insert and remove
//
//  channel   dir  tdata (low bit up)     tuser (low bit up)
//  s_axis    in   data_value[31:0]       func[2:0]
//  m_axis    out  popped_value[31:0]     status[1:0]
//
//  one request at a time; sorted insert/remove scan or move stored words one by one,
//  each word taking a read state and then a compare/write state, set by the
//  registered read of the word store (read, then compare/write)
//  the next request is taken while an earlier result still waits in the output register
//  synchronous active-low reset empties the store (head = tail = 0) and drops o_m_axis_tvalid
//  a stalled output holds the finished result and the next one waits in the controller
module circular_deque_sorted_list_top
    import cdsl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [DATA_W-1:0]   i_s_axis_tdata,   // data_value
    input  logic [FUNC_W-1:0]   i_s_axis_tuser,   // func
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [DATA_W-1:0]   o_m_axis_tdata,   // popped_value
    output logic [STATUS_W-1:0] o_m_axis_tuser    // status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller
    cdsl_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (dp_stat),
        .o_cmd           (dp_cmd)
    );

    // datapath
    cdsl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_func          (i_s_axis_tuser),
        .i_data          (i_s_axis_tdata),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // a taken request keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready
    ) else $error("input ready right after a request was taken");

    // a command with an error status returns a zero word
    a_zero_on_error: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> (o_m_axis_tdata == '0)
    ) else $error("nonzero popped word with error status");

    // the store can never look both full and empty
    a_full_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(dp_stat.full && dp_stat.empty)
    ) else $error("store flagged full and empty at once");

    // a result is loaded only into a free output slot
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.out_ld) |-> (!o_m_axis_tvalid || i_m_axis_tready)
    ) else $error("pending result overwritten");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the circular deque with sorted insert and remove
`timescale 1ns / 100ps

module tb_top
    import cdsl_pkg::*;
();

    // func codes the block ignores
    localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] WORD_NEG = 32'hffff_ffff;

    localparam int RANDOM_REQUESTS = 750;
    localparam int CALM_REQUESTS   = 70;
    localparam int DRAIN_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] popped;
    } t_response;

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] val;
        int                reps;
        bit                known;
        t_status           status;
        logic [DATA_W-1:0] popped;
    } t_req_row;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ORDERED, MIX_CHURN} t_mix;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [DATA_W-1:0]   i_s_axis_tdata = '0;   // data_value
    logic [FUNC_W-1:0]   i_s_axis_tuser = '0;   // func
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   o_m_axis_tdata;        // popped_value
    logic [STATUS_W-1:0] o_m_axis_tuser;        // status

    // model of the deque contents
    logic [DATA_W-1:0] model_words [STORE_DEPTH];
    int                model_head = 0;
    int                model_tail = 0;

    t_response pending_responses [$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        gap_pct = 20;
    int        stall_pct = 20;
    bit        wind_down = 1'b0;
    int        stall_left = 0;

    // directed requests, from the empty store up to full
    t_req_row directed_rows [22] = '{
        '{FN_POP_FRONT,  32'd0,     1, 1'b1, ST_EMPTY,    32'd0},
        '{FN_POP_BACK,   32'd0,     1, 1'b1, ST_EMPTY,    32'd0},
        '{FN_REMOVE,     32'd5,     1, 1'b1, ST_EMPTY,    32'd0},
        '{FN_UNUSED_6,   WORD_NEG,  1, 1'b1, ST_OK,       32'd0},
        '{FN_UNUSED_7,   WORD_MAX,  1, 1'b1, ST_OK,       32'd0},
        '{FN_INSERT,     WORD_MAX,  1, 1'b1, ST_OK,       32'd0},
        '{FN_INSERT,     WORD_MIN,  1, 1'b1, ST_OK,       32'd0},
        '{FN_INSERT,     32'd0,     1, 1'b1, ST_OK,       32'd0},
        '{FN_INSERT,     32'd0,     1, 1'b1, ST_OK,       32'd0},
        '{FN_PUSH_FRONT, WORD_NEG,  1, 1'b1, ST_OK,       32'd0},
        '{FN_PUSH_BACK,  32'd5,     1, 1'b1, ST_OK,       32'd0},
        '{FN_INSERT,     32'd3,     1, 1'b0, ST_OK,       32'd0},
        '{FN_REMOVE,     32'd0,     1, 1'b0, ST_OK,       32'd0},
        '{FN_REMOVE,     32'd12345, 1, 1'b1, ST_NOTFOUND, 32'd0},
        '{FN_POP_FRONT,  32'd0,     1, 1'b0, ST_OK,       32'd0},
        '{FN_POP_BACK,   32'd0,     1, 1'b0, ST_OK,       32'd0},
        '{FN_PUSH_BACK,  32'd100,  11, 1'b0, ST_OK,       32'd0},
        '{FN_PUSH_FRONT, 32'd7,     1, 1'b1, ST_FULL,     32'd0},
        '{FN_INSERT,     32'd7,     1, 1'b1, ST_FULL,     32'd0},
        '{FN_REMOVE,     WORD_MAX,  1, 1'b0, ST_OK,       32'd0},
        '{FN_INSERT,     32'd50,    1, 1'b0, ST_OK,       32'd0},
        '{FN_PUSH_BACK,  32'd9,     1, 1'b1, ST_FULL,     32'd0}
    };

    circular_deque_sorted_list_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int wrap_next(input int i);
        return (i + 1) % STORE_DEPTH;
    endfunction

    function automatic int wrap_prev(input int i);
        return (i + STORE_DEPTH - 1) % STORE_DEPTH;
    endfunction

    function automatic int word_count();
        return (model_tail - model_head + STORE_DEPTH) % STORE_DEPTH;
    endfunction

    // apply one request to the model and return the response it gives
    function automatic t_response apply_request(input logic [FUNC_W-1:0] fn,
                                                input logic [DATA_W-1:0] val);
        t_response rsp;
        int        hit;
        int        pos;
        bit        full;
        bit        empty;
        rsp.status = ST_OK;
        rsp.popped = '0;
        full  = (model_head == wrap_next(model_tail));
        empty = (model_head == model_tail);
        case (fn)
            FN_PUSH_FRONT: begin
                if (full) rsp.status = ST_FULL;
                else begin
                    model_head = wrap_prev(model_head);
                    model_words[model_head] = val;
                end
            end
            FN_PUSH_BACK: begin
                if (full) rsp.status = ST_FULL;
                else begin
                    model_words[model_tail] = val;
                    model_tail = wrap_next(model_tail);
                end
            end
            FN_POP_FRONT: begin
                if (empty) rsp.status = ST_EMPTY;
                else begin
                    rsp.popped = model_words[model_head];
                    model_head = wrap_next(model_head);
                end
            end
            FN_POP_BACK: begin
                if (empty) rsp.status = ST_EMPTY;
                else begin
                    model_tail = wrap_prev(model_tail);
                    rsp.popped = model_words[model_tail];
                end
            end
            FN_INSERT: begin
                if (full) rsp.status = ST_FULL;
                else begin
                    // stop at the first word greater than the new one
                    hit = model_head;
                    while (hit != model_tail && $signed(model_words[hit]) <= $signed(val))
                        hit = wrap_next(hit);
                    for (pos = model_tail; pos != hit; pos = wrap_prev(pos))
                        model_words[pos] = model_words[wrap_prev(pos)];
                    model_words[hit] = val;
                    model_tail = wrap_next(model_tail);
                end
            end
            FN_REMOVE: begin
                if (empty) rsp.status = ST_EMPTY;
                else begin
                    hit = model_head;
                    while (hit != model_tail && model_words[hit] != val)
                        hit = wrap_next(hit);
                    if (hit == model_tail) rsp.status = ST_NOTFOUND;
                    else begin
                        // close the gap over the stored words only
                        for (pos = hit; wrap_next(pos) != model_tail; pos = wrap_next(pos))
                            model_words[pos] = model_words[wrap_next(pos)];
                        model_tail = wrap_prev(model_tail);
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic logic [DATA_W-1:0] stored_word();
        return model_words[(model_head + $urandom_range(word_count() - 1)) % STORE_DEPTH];
    endfunction

    // weighted command choice per traffic mix
    function automatic logic [FUNC_W-1:0] pick_func(input t_mix mix);
        int w [6];
        int total;
        int r;
        int i;
        if ($urandom_range(99) < 2) return $urandom_range(1) ? FN_UNUSED_7 : FN_UNUSED_6;
        case (mix)
            MIX_GROW:    w = '{25, 25, 5, 5, 30, 10};
            MIX_SHRINK:  w = '{5, 5, 30, 30, 5, 25};
            MIX_ORDERED: w = '{0, 0, 10, 10, 45, 35};
            default:     w = '{17, 17, 17, 17, 16, 16};
        endcase
        total = 0;
        for (i = 0; i < 6; i++) total += w[i];
        r = $urandom_range(total - 1);
        for (i = 0; i < 6; i++) begin
            if (r < w[i]) return FUNC_W'(i);
            r -= w[i];
        end
        return FN_PUSH_BACK;
    endfunction

    // word mix: small values for ties, stored words, extremes, full range
    function automatic logic [DATA_W-1:0] pick_word(input logic [FUNC_W-1:0] fn);
        int r;
        r = $urandom_range(99);
        if (fn == FN_REMOVE && word_count() > 0 && r < 75) return stored_word();
        r = $urandom_range(99);
        if (r < 35) return DATA_W'(int'($urandom_range(12)) - 6);
        if (r < 50 && word_count() > 0) return stored_word();
        if (r < 62) begin
            case ($urandom_range(3))
                0: return WORD_MIN;
                1: return WORD_MAX;
                2: return WORD_NEG;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // drive one request, wait for it to be taken, then log its response
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val,
                                input bit known, input t_status status,
                                input logic [DATA_W-1:0] popped);
        t_response rsp;
        if (!wind_down && $urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= val;
        i_s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        rsp = apply_request(fn, val);
        if (known) begin
            rsp.status = status;
            rsp.popped = popped;
        end
        pending_responses.push_back(rsp);
    endtask

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left == 0 && !wind_down && $urandom_range(99) < stall_pct)
            stall_left = $urandom_range(15, 1);
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // compare each response with the oldest pending one
    always @(posedge i_clk) begin
        t_response want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with nothing pending", o_m_axis_tdata, '0);
            end else begin
                want = pending_responses.pop_front();
                if (o_m_axis_tuser !== want.status)
                    report_mismatch("status", DATA_W'(o_m_axis_tuser), DATA_W'(want.status));
                if (o_m_axis_tdata !== want.popped)
                    report_mismatch("popped word", o_m_axis_tdata, want.popped);
            end
        end
    end

    // cycles with no request and no response taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[%0t] no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reset, directed table, then random traffic in phases
    initial begin
        int   k;
        int   n;
        int   phase_left;
        t_mix mix;
        logic [FUNC_W-1:0] fn;
        for (k = 0; k < STORE_DEPTH; k++) model_words[k] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            for (k = 0; k < directed_rows[i].reps; k++)
                send_request(directed_rows[i].fn, directed_rows[i].val + DATA_W'(k),
                             directed_rows[i].known, directed_rows[i].status,
                             directed_rows[i].popped);
        end

        phase_left = 0;
        mix = MIX_CHURN;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(50, 15);
                mix = t_mix'($urandom_range(3));
                case ($urandom_range(3))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    2: gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            phase_left--;
            if (n == RANDOM_REQUESTS - CALM_REQUESTS) wind_down = 1'b1;
            fn = pick_func(mix);
            send_request(fn, pick_word(fn), 1'b0, ST_OK, '0);
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
src/cdsl_pkg.sv
src/cdsl_dp.sv
src/cdsl_ctrl.sv
src/circular_deque_sorted_list_top.sv
tb/tb_top.sv
